FILE: hw/rtl/rc6_pkg.sv
// ----------------------------------------------------------------------------
// rc6_pkg
// Shared types and constants for the RC6 mode-0 infrared frame decoder.
// ----------------------------------------------------------------------------
package rc6_pkg;

    localparam int HEADER_BIT_COUNT = 4;
    localparam int DATA_BIT_COUNT   = 16;

    localparam int UNIT_W   = 12;
    localparam int TOL_W    = 7;
    localparam int DUR_W    = 16;
    localparam int CNT_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 12;
    localparam int NUM_K    = 4;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 12'd444;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 7'd25;
    localparam logic [TOL_W-1:0]  TOL_MAX    = 7'd99;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL  = 1'b1;

    // expected-duration multiples, in units
    localparam logic [1:0] K1_IDX = 2'd0;
    localparam logic [1:0] K2_IDX = 2'd1;
    localparam logic [1:0] K3_IDX = 2'd2;
    localparam logic [1:0] K6_IDX = 2'd3;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LEADER = 3'd1,
        ST_BAD_TIMING = 3'd2,
        ST_BAD_MODE   = 3'd3,
        ST_EARLY_END  = 3'd4
    } status_t;

    typedef logic [DUR_W-1:0] dur_t;

    typedef struct packed {
        logic                  busy;
        dur_t [NUM_K-1:0]      lo;
        dur_t [NUM_K-1:0]      hi;
    } thr_bus_t;

endpackage

FILE: hw/rtl/rc6_thresh.sv
// ----------------------------------------------------------------------------
// rc6_thresh
// Configuration registers and window limit unit: works out the lower and
// upper duration limits for 1, 2, 3 and 6 units, one limit per cycle.
// ----------------------------------------------------------------------------
module rc6_thresh
    import rc6_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output thr_bus_t              thr
);

    localparam int X_W      = 23;
    localparam int PROD_W   = 47;
    localparam int SEQ_W    = 4;
    localparam int RECIP_SHIFT = 30;
    localparam logic [23:0] RECIP = 24'd10737419;   // ceil(2^30 / 100)
    localparam logic [SEQ_W-1:0] SEQ_ISSUE_END = 4'd8;
    localparam logic [SEQ_W-1:0] SEQ_DONE      = 4'd10;

    logic [UNIT_W-1:0] unit_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [SEQ_W-1:0]  seq_reg;

    logic              a_valid_reg;
    logic [2:0]        a_idx_reg;
    logic [X_W-1:0]    a_x_reg;
    logic              b_valid_reg;
    logic [2:0]        b_idx_reg;
    dur_t              b_q_reg;

    dur_t              lo_reg [NUM_K];
    dur_t              hi_reg [NUM_K];

    logic [TOL_W-1:0]  tol_eff;
    logic [7:0]        factor;
    logic [14:0]       unit_k;
    logic [X_W-1:0]    x_next;
    logic [PROD_W-1:0] prod;
    logic [2:0]        idx;
    logic              issue;

    assign cfg_ready = 1'b1;
    assign idx       = seq_reg[2:0];
    assign issue     = seq_reg < SEQ_ISSUE_END;
    assign tol_eff   = (tol_reg > TOL_MAX) ? TOL_MAX : tol_reg;

    always_comb
    begin
        case (idx[1:0])
            K1_IDX:  unit_k = {3'b000, unit_reg};
            K2_IDX:  unit_k = {2'b00, unit_reg, 1'b0};
            K3_IDX:  unit_k = {3'b000, unit_reg} + {2'b00, unit_reg, 1'b0};
            default: unit_k = {2'b00, unit_reg, 1'b0} + {1'b0, unit_reg, 2'b00};
        endcase
        if (idx[2])
        begin
            factor = 8'd100 + {1'b0, tol_eff};
        end
        else
        begin
            factor = 8'd100 - {1'b0, tol_eff};
        end
        x_next = X_W'(unit_k) * X_W'(factor);
    end

    assign prod = PROD_W'(a_x_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg    <= UNIT_RESET;
            tol_reg     <= TOL_RESET;
            seq_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_UNIT)
                begin
                    unit_reg <= cfg_data[UNIT_W-1:0];
                end
                else
                begin
                    tol_reg <= cfg_data[TOL_W-1:0];
                end
                seq_reg <= '0;
            end
            else if (seq_reg != SEQ_DONE)
            begin
                seq_reg <= seq_reg + 1'b1;
            end
            a_valid_reg <= issue;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_idx_reg <= idx;
        a_x_reg   <= x_next;
        b_idx_reg <= a_idx_reg;
        b_q_reg   <= prod[RECIP_SHIFT+DUR_W-1:RECIP_SHIFT];
        if (b_valid_reg)
        begin
            if (b_idx_reg[2])
            begin
                hi_reg[b_idx_reg[1:0]] <= b_q_reg;
            end
            else
            begin
                lo_reg[b_idx_reg[1:0]] <= b_q_reg;
            end
        end
    end

    always_comb
    begin
        thr.busy = seq_reg != SEQ_DONE;
        for (int i = 0; i < NUM_K; i++)
        begin
            thr.lo[i] = lo_reg[i];
            thr.hi[i] = hi_reg[i];
        end
    end

endmodule

FILE: hw/rtl/rc6_decode.sv
// ----------------------------------------------------------------------------
// rc6_decode
// Pulse input register, frame state and result register.
// ----------------------------------------------------------------------------
module rc6_decode
    import rc6_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  thr_bus_t    thr,
    input  logic        pulse_valid,
    output logic        pulse_stall,
    input  logic        pulse_level,
    input  logic [15:0] pulse_duration,
    input  logic        capture_start,
    input  logic        capture_end,
    output logic        frame_valid,
    input  logic        frame_stall,
    output logic [2:0]  status,
    output logic [2:0]  frame_mode,
    output logic        toggle_bit,
    output logic [7:0]  device_address,
    output logic [7:0]  command_code
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LSPACE,
        PH_HEADER,
        PH_TOGGLE,
        PH_DATA
    } phase_t;

    localparam logic [CNT_W-1:0] HDR_LAST  = CNT_W'(HEADER_BIT_COUNT - 1);
    localparam logic [CNT_W-1:0] DATA_LAST = CNT_W'(DATA_BIT_COUNT - 1);

    logic                      in_valid_reg;
    logic                      level_reg;
    dur_t                      dur_reg;
    logic                      start_reg;
    logic                      end_reg;

    phase_t                    phase_reg, phase_next;
    logic                      half_reg, half_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [3:0]                hdr_reg, hdr_next;
    logic [DATA_BIT_COUNT-1:0] data_reg, data_next;
    logic                      tog_reg, tog_next;

    logic                      out_valid_reg;
    status_t                   status_reg, status_next;
    logic [2:0]                mode_reg, mode_next;
    logic                      tog_out_reg, tog_out_next;
    logic [7:0]                addr_reg, addr_next;
    logic [7:0]                cmd_reg, cmd_next;

    logic [NUM_K-1:0]          fit;
    logic                      advance;
    logic                      accept;
    logic                      res;
    logic                      cur_fit;
    logic                      mrg_fit;
    logic                      do_open;
    logic                      do_close;

    assign advance     = in_valid_reg && (!out_valid_reg || !frame_stall);
    assign pulse_stall = thr.busy || (in_valid_reg && !advance);
    assign accept      = pulse_valid && !pulse_stall;

    always_comb
    begin
        for (int i = 0; i < NUM_K; i++)
        begin
            fit[i] = (dur_reg >= thr.lo[i]) && (dur_reg <= thr.hi[i]);
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        half_next   = half_reg;
        cnt_next    = cnt_reg;
        hdr_next    = hdr_reg;
        data_next   = data_reg;
        tog_next    = tog_reg;
        res         = 1'b0;
        status_next = ST_OK;
        do_open     = 1'b0;
        do_close    = 1'b0;

        cur_fit = (phase_reg == PH_TOGGLE) ? fit[K2_IDX] : fit[K1_IDX];
        mrg_fit = ((phase_reg == PH_TOGGLE) ||
                   (phase_reg == PH_HEADER && cnt_reg == HDR_LAST)) ?
                  fit[K3_IDX] : fit[K2_IDX];

        if (start_reg)
        begin
            half_next = 1'b0;
            cnt_next  = '0;
            hdr_next  = '0;
            data_next = '0;
            tog_next  = 1'b0;
            if (level_reg && fit[K6_IDX])
            begin
                phase_next = PH_LSPACE;
            end
            else
            begin
                phase_next  = PH_IDLE;
                res         = 1'b1;
                status_next = ST_BAD_LEADER;
            end
        end
        else if (phase_reg == PH_LSPACE)
        begin
            if (!level_reg && fit[K2_IDX])
            begin
                phase_next = PH_HEADER;
                cnt_next   = '0;
                half_next  = 1'b0;
            end
            else
            begin
                res         = 1'b1;
                status_next = ST_BAD_LEADER;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (!half_reg)
            begin
                if (cur_fit)
                begin
                    do_open = 1'b1;
                end
                else
                begin
                    res         = 1'b1;
                    status_next = ST_BAD_TIMING;
                end
            end
            else if (cur_fit)
            begin
                do_close = 1'b1;
            end
            else if (mrg_fit)
            begin
                do_close = 1'b1;
                do_open  = 1'b1;
            end
            else
            begin
                res         = 1'b1;
                status_next = ST_BAD_TIMING;
            end
        end

        if (do_close)
        begin
            half_next = 1'b0;
            if (phase_reg == PH_HEADER)
            begin
                if (cnt_reg == HDR_LAST)
                begin
                    phase_next = PH_TOGGLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            else if (phase_reg == PH_TOGGLE)
            begin
                phase_next = PH_DATA;
                cnt_next   = '0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end

        if (do_open)
        begin
            half_next = 1'b1;
            if (phase_next == PH_HEADER)
            begin
                hdr_next = {hdr_reg[2:0], level_reg};
                if (cnt_next == HDR_LAST && hdr_next[2:0] != 3'b000)
                begin
                    res         = 1'b1;
                    status_next = ST_BAD_MODE;
                end
            end
            else if (phase_next == PH_TOGGLE)
            begin
                tog_next = level_reg;
            end
            else
            begin
                data_next = {data_reg[DATA_BIT_COUNT-2:0], level_reg};
                if (cnt_next == DATA_LAST)
                begin
                    res         = 1'b1;
                    status_next = ST_OK;
                end
            end
        end

        // idle pulses without a start give nothing, even at capture end
        if (!res && end_reg && (start_reg || phase_reg != PH_IDLE))
        begin
            res         = 1'b1;
            status_next = ST_EARLY_END;
        end

        mode_next    = (status_next == ST_OK || status_next == ST_BAD_MODE) ?
                       hdr_next[2:0] : 3'b000;
        tog_out_next = (status_next == ST_OK) ? tog_next : 1'b0;
        addr_next    = (status_next == ST_OK) ?
                       data_next[DATA_BIT_COUNT-1 -: 8] : 8'h00;
        cmd_next     = (status_next == ST_OK) ? data_next[7:0] : 8'h00;

        if (res)
        begin
            phase_next = PH_IDLE;
            half_next  = 1'b0;
            cnt_next   = '0;
            hdr_next   = '0;
            data_next  = '0;
            tog_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            half_reg      <= 1'b0;
            cnt_reg       <= '0;
            hdr_reg       <= '0;
            data_reg      <= '0;
            tog_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                half_reg  <= half_next;
                cnt_reg   <= cnt_next;
                hdr_reg   <= hdr_next;
                data_reg  <= data_next;
                tog_reg   <= tog_next;
            end
            if (advance && res)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!frame_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg <= pulse_level;
            dur_reg   <= pulse_duration;
            start_reg <= capture_start;
            end_reg   <= capture_end;
        end
        if (advance && res)
        begin
            status_reg  <= status_next;
            mode_reg    <= mode_next;
            tog_out_reg <= tog_out_next;
            addr_reg    <= addr_next;
            cmd_reg     <= cmd_next;
        end
    end

    assign frame_valid    = out_valid_reg;
    assign status         = status_reg;
    assign frame_mode     = mode_reg;
    assign toggle_bit     = tog_out_reg;
    assign device_address = addr_reg;
    assign command_code   = cmd_reg;

endmodule

FILE: hw/rtl/rc6_ir_frame_decoder.sv
// ----------------------------------------------------------------------------
// rc6_ir_frame_decoder
// RC6 mode-0 infrared frame decoder fed with measured pulses.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  pulse    | pulse_valid/pulse_stall| pulse_level, pulse_duration,
//           |                        | capture_start, capture_end
//  frame    | frame_valid/frame_stall| status, frame_mode, toggle_bit,
//           |                        | device_address, command_code
//  cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One pulse item per cycle while pulse_stall is low; the frame result is
// registered in the result register from the pulse register holding the
// pulse item that ends the frame. After reset and after each config write,
// pulse_stall stays high while the window limit unit (two registered
// multiplies) refills its eight limits, one per cycle.
// frame_stall holds the result register; the pulse register then holds
// one more item before pulse_stall rises.
// ----------------------------------------------------------------------------
module rc6_ir_frame_decoder
    import rc6_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pulse_valid,
    output logic                  pulse_stall,
    input  logic                  pulse_level,
    input  logic [15:0]           pulse_duration,
    input  logic                  capture_start,
    input  logic                  capture_end,
    output logic                  frame_valid,
    input  logic                  frame_stall,
    output logic [2:0]            status,
    output logic [2:0]            frame_mode,
    output logic                  toggle_bit,
    output logic [7:0]            device_address,
    output logic [7:0]            command_code,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    thr_bus_t thr;

    rc6_thresh u_thresh
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thr       (thr)
    );

    rc6_decode u_decode
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .thr            (thr),
        .pulse_valid    (pulse_valid),
        .pulse_stall    (pulse_stall),
        .pulse_level    (pulse_level),
        .pulse_duration (pulse_duration),
        .capture_start  (capture_start),
        .capture_end    (capture_end),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .status         (status),
        .frame_mode     (frame_mode),
        .toggle_bit     (toggle_bit),
        .device_address (device_address),
        .command_code   (command_code)
    );

endmodule
